// ----- src/q4q8dp_pkg.sv -----
`timescale 1ns / 1ps
package q4q8dp_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    typedef struct packed {
        logic       load;
        logic       dot;
        logic [1:0] dot_idx;
        logic       cvt;
        logic       mul_a;
        logic       use_dy;
        logic       norm_t;
        logic       add_a;
        logic       norm_sum;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

    function automatic logic [31:0] f_half_to_single(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [9:0] mn;
        logic [7:0] ex;
        logic [31:0] r;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) p = 4'(i);
        end
        mn = m << (4'd10 - p);
        ex = 8'd103 + 8'(p);
        if (e == 5'd0) begin
            r = (m == 10'd0) ? {s, 31'd0} : {s, ex, mn, 13'd0};
        end else if (e == 5'd31) begin
            r = (m != 10'd0) ? CANON_NAN : {s, 8'hFF, 23'd0};
        end else begin
            r = {s, 8'(e) + 8'd112, m, 13'd0};
        end
        return r;
    endfunction

    // value = s * 2^e, rounded to fp32 nearest-even
    function automatic logic [31:0] f_round(input logic sgn, input logic [47:0] s,
                                            input logic signed [11:0] e);
        logic [5:0]         lz;
        logic [47:0]        nm;
        logic signed [12:0] be;
        logic [12:0]        sh;
        logic               stk;
        logic [23:0]        m;
        logic               g;
        logic               st;
        logic               up;
        logic [24:0]        mr;
        logic [31:0]        r;
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (s[i]) lz = 6'(47 - i);
        end
        nm  = s << lz;
        be  = $signed({e[11], e}) + 13'sd174 - $signed({7'd0, lz});
        stk = 1'b0;
        if (be <= 13'sd0) begin
            sh = 13'(13'sd1 - be);
            if (sh >= 13'd48) begin
                stk = |nm;
                nm  = 48'd0;
            end else begin
                stk = |(nm & ((48'd1 << sh[5:0]) - 48'd1));
                nm  = nm >> sh[5:0];
            end
        end
        m  = nm[47:24];
        g  = nm[23];
        st = (|nm[22:0]) | stk;
        up = g & (st | m[0]);
        mr = {1'b0, m} + 25'(up);
        if (s == 48'd0) begin
            r = {sgn, 31'd0};
        end else if (be >= 13'sd255) begin
            r = {sgn, 8'hFF, 23'd0};
        end else if (be <= 13'sd0) begin
            r = {sgn, 7'd0, mr[23], mr[22:0]};
        end else if (mr[24]) begin
            r = {sgn, be[7:0] + 8'd1, 23'd0};
        end else begin
            r = {sgn, be[7:0], mr[22:0]};
        end
        return r;
    endfunction

endpackage

// ----- src/q4q8dp_if.sv -----
`timescale 1ns / 1ps
interface q4q8dp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_scale;
    logic [63:0] x_nibbles_low;
    logic [63:0] x_nibbles_high;
    logic [15:0] y_scale;
    logic [63:0] y_quants_0;
    logic [63:0] y_quants_1;
    logic [63:0] y_quants_2;
    logic [63:0] y_quants_3;
    logic        last_block;

    modport source (output valid, x_scale, x_nibbles_low, x_nibbles_high, y_scale,
                    y_quants_0, y_quants_1, y_quants_2, y_quants_3, last_block,
                    input ready);
    modport sink (input valid, x_scale, x_nibbles_low, x_nibbles_high, y_scale,
                  y_quants_0, y_quants_1, y_quants_2, y_quants_3, last_block,
                  output ready);
endinterface

interface q4q8dp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_sum;

    modport source (output valid, dot_sum, input ready);
    modport sink (input valid, dot_sum, output ready);
endinterface

// ----- src/q4q8dp_ctrl.sv -----
`timescale 1ns / 1ps
module q4q8dp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  q4q8dp_pkg::t_sts  i_sts,
    output q4q8dp_pkg::t_cmd  o_cmd
);
    import q4q8dp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DOT, ST_CVT, ST_M1A, ST_M1B, ST_M2A, ST_M2B, ST_ADA, ST_ADB, ST_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       out_busy;

    assign out_busy    = r_out_valid & ~i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.dot_idx = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = 2'd0;
                    n_state    = ST_DOT;
                end
            end
            ST_DOT: begin
                o_cmd.dot = 1'b1;
                n_cnt     = r_cnt + 2'd1;
                if (r_cnt == 2'd3) n_state = ST_CVT;
            end
            ST_CVT: begin
                o_cmd.cvt = 1'b1;
                n_state   = ST_M1A;
            end
            ST_M1A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = ST_M1B;
            end
            ST_M1B: begin
                o_cmd.norm_t = 1'b1;
                n_state      = ST_M2A;
            end
            ST_M2A: begin
                o_cmd.mul_a  = 1'b1;
                o_cmd.use_dy = 1'b1;
                n_state      = ST_M2B;
            end
            ST_M2B: begin
                o_cmd.norm_t = 1'b1;
                n_state      = ST_ADA;
            end
            ST_ADA: begin
                o_cmd.add_a = 1'b1;
                n_state     = ST_ADB;
            end
            ST_ADB: begin
                o_cmd.norm_sum = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                // hold the last block until the output register is free
                if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (!out_busy) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ----- src/q4q8dp_dpath.sv -----
`timescale 1ns / 1ps
module q4q8dp_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  q4q8dp_pkg::t_cmd  i_cmd,
    input  logic [15:0]       i_x_scale,
    input  logic [127:0]      i_x_bytes,
    input  logic [15:0]       i_y_scale,
    input  logic [255:0]      i_y_bytes,
    input  logic              i_last_block,
    output q4q8dp_pkg::t_sts  o_sts,
    output logic [31:0]       o_dot_sum
);
    import q4q8dp_pkg::*;

    logic [15:0]        r_xs, r_ys;
    logic [127:0]       r_xb;
    logic [255:0]       r_yb;
    logic               r_last;
    logic signed [16:0] r_acc;
    logic [31:0]        r_dx, r_dy, r_t, r_sum, r_dot;
    logic               r_sp, r_ps;
    logic [31:0]        r_spv;
    logic [47:0]        r_prod;
    logic signed [11:0] r_pe;

    logic signed [16:0] part;
    logic [16:0]        acc_mag;

    // 8 products of one dot step
    always_comb begin
        logic [3:0]         j;
        logic [7:0]         xb;
        logic signed [4:0]  lo, hi;
        logic signed [7:0]  ya, yb;
        part = '0;
        for (int k = 0; k < 4; k++) begin
            j  = {i_cmd.dot_idx, 2'(k)};
            xb = r_xb[8*j +: 8];
            lo = $signed({1'b0, xb[3:0]}) - 5'sd8;
            hi = $signed({1'b0, xb[7:4]}) - 5'sd8;
            ya = $signed(r_yb[8*j +: 8]);
            yb = $signed(r_yb[128 + 8*j +: 8]);
            part = part + 17'(lo) * 17'(ya) + 17'(hi) * 17'(yb);
        end
    end

    assign acc_mag = r_acc[16] ? 17'(-r_acc) : 17'(r_acc);

    // multiply front end
    logic [31:0]        mb;
    logic               ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
    logic [7:0]         mea, meb;
    logic [47:0]        mprod;
    always_comb begin
        mb      = i_cmd.use_dy ? r_dy : r_dx;
        ma_nan  = (r_t[30:23] == 8'hFF) && (r_t[22:0] != 23'd0);
        mb_nan  = (mb[30:23] == 8'hFF) && (mb[22:0] != 23'd0);
        ma_inf  = (r_t[30:0] == 31'h7F80_0000);
        mb_inf  = (mb[30:0] == 31'h7F80_0000);
        ma_zero = (r_t[30:0] == 31'd0);
        mb_zero = (mb[30:0] == 31'd0);
        mea     = (r_t[30:23] == 8'd0) ? 8'd1 : r_t[30:23];
        meb     = (mb[30:23] == 8'd0) ? 8'd1 : mb[30:23];
        mprod   = {r_t[30:23] != 8'd0, r_t[22:0]} * {mb[30:23] != 8'd0, mb[22:0]};
    end

    // add front end: big operand first
    logic [31:0] aa, ab, big, sml;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  eb_big, eb_sml, ediff;
    logic [26:0] mbig, msml, mal;
    logic        stk;
    logic [27:0] asum;
    always_comb begin
        aa     = r_sum;
        ab     = r_t;
        a_nan  = (aa[30:23] == 8'hFF) && (aa[22:0] != 23'd0);
        b_nan  = (ab[30:23] == 8'hFF) && (ab[22:0] != 23'd0);
        a_inf  = (aa[30:0] == 31'h7F80_0000);
        b_inf  = (ab[30:0] == 31'h7F80_0000);
        if (aa[30:0] >= ab[30:0]) begin
            big = aa;
            sml = ab;
        end else begin
            big = ab;
            sml = aa;
        end
        eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        ediff  = eb_big - eb_sml;
        mbig   = {big[30:23] != 8'd0, big[22:0], 3'd0};
        msml   = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        if (ediff >= 8'd27) begin
            mal = 27'd0;
            stk = |msml;
        end else begin
            mal = msml >> ediff[4:0];
            stk = |(msml & ((27'd1 << ediff[4:0]) - 27'd1));
        end
        mal[0] = mal[0] | stk;
        if (big[31] == sml[31]) asum = {1'b0, mbig} + {1'b0, mal};
        else                    asum = {1'b0, mbig} - {1'b0, mal};
    end

    logic [31:0] rnd;
    assign rnd = r_sp ? r_spv : f_round(r_ps, r_prod, r_pe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= POS_ZERO;
        end else begin
            if (i_cmd.norm_sum) r_sum <= rnd;
            else if (i_cmd.emit) r_sum <= POS_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs   <= i_x_scale;
            r_xb   <= i_x_bytes;
            r_ys   <= i_y_scale;
            r_yb   <= i_y_bytes;
            r_last <= i_last_block;
            r_acc  <= '0;
        end
        if (i_cmd.dot) r_acc <= r_acc + part;
        if (i_cmd.cvt) begin
            r_dx <= f_half_to_single(r_xs);
            r_dy <= f_half_to_single(r_ys);
            r_t  <= f_round(r_acc[16], {31'd0, acc_mag}, 12'sd0);
        end
        if (i_cmd.mul_a) begin
            r_sp   <= ma_nan | mb_nan | ma_inf | mb_inf;
            r_spv  <= (ma_nan | mb_nan | (ma_inf & mb_zero) | (mb_inf & ma_zero))
                      ? CANON_NAN : {r_t[31] ^ mb[31], 31'h7F80_0000};
            r_ps   <= r_t[31] ^ mb[31];
            r_prod <= mprod;
            r_pe   <= $signed({4'd0, mea}) + $signed({4'd0, meb}) - 12'sd300;
        end
        if (i_cmd.add_a) begin
            r_sp   <= a_nan | b_nan | a_inf | b_inf;
            r_spv  <= (a_nan | b_nan | (a_inf & b_inf & (aa[31] != ab[31])))
                      ? CANON_NAN : (a_inf ? aa : ab);
            r_ps   <= (asum == 28'd0) ? (aa[31] & ab[31]) : big[31];
            r_prod <= {20'd0, asum};
            r_pe   <= $signed({4'd0, eb_big}) - 12'sd153;
        end
        if (i_cmd.norm_t) r_t <= rnd;
        if (i_cmd.emit) r_dot <= r_sum;
    end

    assign o_sts.last = r_last;
    assign o_dot_sum  = r_dot;
endmodule

// ----- src/q4_q8_block_dot_product.sv -----
`timescale 1ns / 1ps
// Q4 x Q8 block dot product with fp32 running sum.
// Per request: accept, 4 integer dot steps (8 products each), int-to-float, two fp multiplies
// and one fp add (each an issue then a round state), write-back; the next request waits for idle.
// A last block's result is loaded into the output register in write-back;
// a last block stalls in write-back while an earlier result is still unaccepted.
// Synchronous active-low reset clears the FSM, output valid and the running sum to +0.
module q4_q8_block_dot_product (
    input  logic  i_clk,
    input  logic  i_rst_n,
    q4q8dp_in_if.sink    i_req,
    q4q8dp_out_if.source o_rsp
);
    import q4q8dp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    q4q8dp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    q4q8dp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_x_scale    (i_req.x_scale),
        .i_x_bytes    ({i_req.x_nibbles_high, i_req.x_nibbles_low}),
        .i_y_scale    (i_req.y_scale),
        .i_y_bytes    ({i_req.y_quants_3, i_req.y_quants_2,
                        i_req.y_quants_1, i_req.y_quants_0}),
        .i_last_block (i_req.last_block),
        .o_sts        (sts),
        .o_dot_sum    (o_rsp.dot_sum)
    );
endmodule

// ----- tb/q4_q8_block_dot_product_tb.sv -----
`timescale 1ns / 1ps
module q4_q8_block_dot_product_tb;
    import q4q8dp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [31:0] FP32_INF = 32'h7F80_0000;

    typedef struct {
        logic [15:0]  xs;
        logic [127:0] xq;
        logic [15:0]  ys;
        logic [255:0] yq;
        logic         last;
    } t_blk;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   idle_en = 1'b1;
    int   errors = 0;
    int   cycles = 0;

    logic [31:0] acc_sum;
    logic [31:0] dot_sum_q[$];

    q4q8dp_in_if  req_if ();
    q4q8dp_out_if rsp_if ();

    q4_q8_block_dot_product i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- fp32 arithmetic, exact then rounded once ----------------

    // round (-1)^s * mag * 2^e to fp32, nearest even
    function automatic logic [31:0] fp32_round(input logic s, input logic [127:0] mag,
                                               input int e);
        int p, u, qe, sh;
        logic [127:0] q;
        logic g, st;
        logic [31:0] r;
        if (mag == 128'd0) return {s, 31'd0};
        p = 0;
        for (int i = 0; i < 128; i++) begin
            if (mag[i]) p = i;
        end
        u = p + e;
        if (u > 127) return {s, FP32_INF[30:0]};
        qe = (u < -126) ? -149 : u - 23;
        sh = qe - e;
        if (sh <= 0) begin
            q = mag << (-sh);
        end else begin
            q  = mag >> sh;
            g  = (sh <= 128) ? mag[sh-1] : 1'b0;
            st = |(mag & ((128'd1 << (sh - 1)) - 128'd1));
            if (g && (st || q[0])) q = q + 128'd1;
        end
        // a rounding carry moves naturally into the exponent field
        if (u < -126) r = q[31:0];
        else r = (32'(u + 126) << 23) + q[31:0];
        if (r[30:0] >= FP32_INF[30:0]) r = FP32_INF;
        return {s, r[30:0]};
    endfunction

    function automatic void fp32_split(input logic [31:0] a, output logic s,
                                       output logic [23:0] m, output int e);
        s = a[31];
        if (a[30:23] == 8'd0) begin
            m = {1'b0, a[22:0]};
            e = -149;
        end else begin
            m = {1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic bit is_nan(input logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic bit is_inf(input logic [31:0] a);
        return a[30:0] == FP32_INF[30:0];
    endfunction

    function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
        if (h[14:10] == 5'h1F) return (h[9:0] != 10'd0) ? CANON_NAN : {h[15], FP32_INF[30:0]};
        if (h[14:10] == 5'd0) return fp32_round(h[15], 128'(h[9:0]), -24);
        return fp32_round(h[15], 128'(h[9:0]) + 128'd1024, int'(h[14:10]) - 25);
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic sa, sb;
        logic [23:0] ma, mb;
        int ea, eb;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
            return {a[31] ^ b[31], FP32_INF[30:0]};
        end
        fp32_split(a, sa, ma, ea);
        fp32_split(b, sb, mb, eb);
        return fp32_round(sa ^ sb, 128'(ma) * 128'(mb), ea + eb);
    endfunction

    function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
        logic sa, sb, s, ts;
        logic [23:0] ma, mb, tm;
        int ea, eb, te, d, e;
        logic [127:0] xa, xb, mag;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        fp32_split(a, sa, ma, ea);
        fp32_split(b, sb, mb, eb);
        if (eb > ea) begin
            ts = sa; sa = sb; sb = ts;
            tm = ma; ma = mb; mb = tm;
            te = ea; ea = eb; eb = te;
        end
        d = ea - eb;
        if (d > 60) begin
            // far below the guard bit: only its sign and presence matter
            xa = 128'(ma) << 50;
            xb = 128'(mb != 24'd0);
            e  = ea - 50;
        end else begin
            xa = 128'(ma) << d;
            xb = 128'(mb);
            e  = eb;
        end
        if (sa == sb) begin
            mag = xa + xb;
            s = sa;
        end else if (xa >= xb) begin
            mag = xa - xb;
            s = sa;
        end else begin
            mag = xb - xa;
            s = sb;
        end
        if (mag == 128'd0) return 32'd0;
        return fp32_round(s, mag, e);
    endfunction

    // ---------------- block predictor ----------------

    function automatic int block_int_dot(input t_blk b);
        int sum, lo, hi, ya, yb;
        logic [7:0] w;
        sum = 0;
        for (int j = 0; j < 16; j++) begin
            w  = b.xq[8*j +: 8];
            lo = int'(w[3:0]) - 8;
            hi = int'(w[7:4]) - 8;
            ya = $signed(b.yq[8*j +: 8]);
            yb = $signed(b.yq[8*(j+16) +: 8]);
            sum += lo * ya + hi * yb;
        end
        return sum;
    endfunction

    task automatic accumulate_block(input t_blk b);
        int sum;
        logic [31:0] t;
        sum = block_int_dot(b);
        t = fp32_round(sum < 0, 128'(sum < 0 ? -sum : sum), 0);
        t = fp32_mul(t, half_to_fp32(b.xs));
        t = fp32_mul(t, half_to_fp32(b.ys));
        acc_sum = fp32_add(acc_sum, t);
        if (b.last) begin
            dot_sum_q.push_back(acc_sum);
            acc_sum = POS_ZERO;
        end
    endtask

    // ---------------- drivers and checker ----------------

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_block(input t_blk b);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.x_scale        <= b.xs;
        req_if.x_nibbles_low  <= b.xq[63:0];
        req_if.x_nibbles_high <= b.xq[127:64];
        req_if.y_scale        <= b.ys;
        req_if.y_quants_0     <= b.yq[63:0];
        req_if.y_quants_1     <= b.yq[127:64];
        req_if.y_quants_2     <= b.yq[191:128];
        req_if.y_quants_3     <= b.yq[255:192];
        req_if.last_block     <= b.last;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        accumulate_block(b);
    endtask

    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 15);
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (dot_sum_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected dot_sum, expected none, actual %h",
                         $time, rsp_if.dot_sum);
            end else begin
                if (rsp_if.dot_sum !== dot_sum_q[0]) begin
                    errors++;
                    $display("%0t: dot_sum mismatch, expected %h, actual %h",
                             $time, dot_sum_q[0], rsp_if.dot_sum);
                end
                void'(dot_sum_q.pop_front());
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return {1'($urandom), 5'd0, 10'($urandom)};
            2: return {1'($urandom), 5'h1F, ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0};
            default: return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
        endcase
    endfunction

    function automatic t_blk rand_block(input logic last);
        t_blk b;
        b.xs   = rand_scale();
        b.ys   = rand_scale();
        b.xq   = {rand64(), rand64()};
        b.yq   = {rand64(), rand64(), rand64(), rand64()};
        b.last = last;
        return b;
    endfunction

    function automatic t_blk mk_block(input logic [15:0] xs, input logic [3:0] nib,
                                      input logic [15:0] ys, input logic [7:0] yv,
                                      input logic last);
        t_blk b;
        b.xs   = xs;
        b.ys   = ys;
        b.xq   = {32{nib}};
        b.yq   = {32{yv}};
        b.last = last;
        return b;
    endfunction

    task automatic test_directed();
        // extreme products: -8 * -128 everywhere gives the largest sum
        send_block(mk_block(16'h3C00, 4'h0, 16'h3C00, 8'h80, 1'b1));
        send_block(mk_block(16'h3C00, 4'hF, 16'h3C00, 8'h80, 1'b1));
        send_block(mk_block(16'h3C00, 4'h8, 16'h3C00, 8'h7F, 1'b1));
        send_block(mk_block(16'h0000, 4'h0, 16'h0000, 8'h00, 1'b1));
        // largest and smallest scales, subnormal halves
        send_block(mk_block(16'h7BFF, 4'h0, 16'h7BFF, 8'h80, 1'b1));
        send_block(mk_block(16'h0001, 4'hF, 16'h0001, 8'h01, 1'b1));
        send_block(mk_block(16'h03FF, 4'h9, 16'h8400, 8'hFF, 1'b1));
        send_block(mk_block(16'h8000, 4'hF, 16'h3C00, 8'h01, 1'b1));
        // infinite and NaN scales, inf times zero
        send_block(mk_block(16'h7C00, 4'h9, 16'h3C00, 8'h01, 1'b1));
        send_block(mk_block(16'hFC00, 4'h9, 16'h3C00, 8'h01, 1'b1));
        send_block(mk_block(16'h7C00, 4'h8, 16'h3C00, 8'h01, 1'b1));
        send_block(mk_block(16'h3C00, 4'h9, 16'h7E00, 8'h01, 1'b1));
        send_block(mk_block(16'hFC01, 4'h9, 16'h3C00, 8'h01, 1'b1));
        // +inf then -inf in one sum
        send_block(mk_block(16'h7C00, 4'h9, 16'h3C00, 8'h01, 1'b0));
        send_block(mk_block(16'hFC00, 4'h9, 16'h3C00, 8'h01, 1'b1));
        // cancellation to zero and a multi-block sum
        send_block(mk_block(16'h3C00, 4'h9, 16'h3C00, 8'h01, 1'b0));
        send_block(mk_block(16'hBC00, 4'h9, 16'h3C00, 8'h01, 1'b1));
        send_block(mk_block(16'h7BFF, 4'h0, 16'h7BFF, 8'h80, 1'b0));
        send_block(mk_block(16'h0001, 4'h9, 16'h0001, 8'h01, 1'b0));
        send_block(mk_block(16'h3555, 4'h3, 16'hC123, 8'h5A, 1'b1));
    endtask

    task automatic test_random_sums(input int n_items);
        int left, len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 1; k <= len && left > 0; k++) begin
                send_block(rand_block(k == len || left == 1));
                left--;
            end
        end
    endtask

    task automatic test_hold_off();
        for (int k = 0; k < 3; k++) send_block(rand_block(k == 2));
        req_if.valid <= 1'b0;
        while (dot_sum_q.size() != 0) @(posedge clk);
        for (int k = 0; k < 3; k++) send_block(rand_block(k == 2));
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        test_random_sums(120);
    endtask

    initial begin
        acc_sum               = POS_ZERO;
        req_if.valid          = 1'b0;
        req_if.x_scale        = '0;
        req_if.x_nibbles_low  = '0;
        req_if.x_nibbles_high = '0;
        req_if.y_scale        = '0;
        req_if.y_quants_0     = '0;
        req_if.y_quants_1     = '0;
        req_if.y_quants_2     = '0;
        req_if.y_quants_3     = '0;
        req_if.last_block     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_sums(700);
        test_hold_off();
        test_random_sums(780);
        test_back_to_back();

        req_if.valid <= 1'b0;
        while (dot_sum_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
